/* hw/rtl/qvr_pkg.sv */
// shared types and widths for the quaternion vector rotate pipeline
// no dependencies; used by quaternion_vector_rotate
package qvr_pkg;

   // field widths
   localparam int QUAT_BITS = 16;
   localparam int VEC_BITS  = 16;

   // internal datapath widths
   localparam int PW   = 2 * QUAT_BITS;              // quaternion square product
   localparam int MW   = QUAT_BITS + VEC_BITS;       // quaternion by vector product
   localparam int DW   = 2 * QUAT_BITS + 1;          // norm squared, unsigned
   localparam int SW   = 2 * QUAT_BITS + 2;          // w^2 - |u|^2
   localparam int DTW  = QUAT_BITS + VEC_BITS + 3;   // twice the dot product
   localparam int CW   = QUAT_BITS + VEC_BITS + 1;   // cross product component
   localparam int W2W  = QUAT_BITS + 1;              // twice w
   localparam int NW   = 2 * QUAT_BITS + VEC_BITS + 5; // numerator
   localparam int QNB  = VEC_BITS + 1;               // quotient bits before rounding
   localparam int CMPW = (NW > DW + QNB) ? NW : DW + QNB;
   localparam int NSTG = QNB + 5;                    // total register stages

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] quat_w;
      logic signed [QUAT_BITS-1:0] quat_x;
      logic signed [QUAT_BITS-1:0] quat_y;
      logic signed [QUAT_BITS-1:0] quat_z;
      logic signed [VEC_BITS-1:0]  vec_x;
      logic signed [VEC_BITS-1:0]  vec_y;
      logic signed [VEC_BITS-1:0]  vec_z;
   } req_type;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] rot_x;
      logic signed [VEC_BITS-1:0] rot_y;
      logic signed [VEC_BITS-1:0] rot_z;
      logic                       zero_quat;
      logic                       clipped;
   } rsp_type;

endpackage

/* hw/rtl/quaternion_vector_rotate.sv */
// quaternion vector rotate: pipelined q * (0,v) * conj(q) / |q|^2 with rounding
// depends on qvr_pkg for payload types and datapath widths
//
// usage
//  - req channel (req_valid/req_ready/req_data) takes one quaternion and one
//    vector per transfer; rsp channel (rsp_valid/rsp_ready/rsp_data) returns
//    the rotated vector plus zero_quat and clipped flags, in order
//  - throughput is one item per clock while rsp_ready is high; every stage is
//    a register with its own valid bit, so bubbles are squeezed out and new
//    items are taken while a finished result waits on rsp
//  - the pipeline has four arithmetic stages (products, sums, second products,
//    numerator), one restoring-division stage per quotient bit and one round
//    and saturate stage; the division stages set the depth
//  - a zero quaternion gives a zero vector with zero_quat set
//  - out-of-range components saturate and set clipped
//  - reset (synchronous, active high) empties the pipeline; no other state
//  - when rsp_ready is low the last stage holds and stages behind it fill
//    up; req_ready drops only once every stage holds an item
module quaternion_vector_rotate
   import qvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // per-stage valid and advance
   logic [NSTG:1]   vld_ff;
   logic [NSTG+1:1] en;

   assign en[NSTG+1] = rsp_ready;
   genvar k;
   generate
      for (k = 1; k <= NSTG; k++) begin : g_en
         assign en[k] = ~vld_ff[k] | en[k+1];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_ready = en[1];

   // stage 1: all first-level products
   logic signed [PW-1:0] pww_ff, pxx_ff, pyy_ff, pzz_ff;
   logic signed [MW-1:0] pxvx_ff, pyvy_ff, pzvz_ff;
   logic signed [MW-1:0] pyvz_ff, pzvy_ff, pzvx_ff, pxvz_ff, pxvy_ff, pyvx_ff;
   req_type              s1_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_ff   <= req_data;
         pww_ff  <= req_data.quat_w * req_data.quat_w;
         pxx_ff  <= req_data.quat_x * req_data.quat_x;
         pyy_ff  <= req_data.quat_y * req_data.quat_y;
         pzz_ff  <= req_data.quat_z * req_data.quat_z;
         pxvx_ff <= MW'(req_data.quat_x) * MW'(req_data.vec_x);
         pyvy_ff <= MW'(req_data.quat_y) * MW'(req_data.vec_y);
         pzvz_ff <= MW'(req_data.quat_z) * MW'(req_data.vec_z);
         pyvz_ff <= MW'(req_data.quat_y) * MW'(req_data.vec_z);
         pzvy_ff <= MW'(req_data.quat_z) * MW'(req_data.vec_y);
         pzvx_ff <= MW'(req_data.quat_z) * MW'(req_data.vec_x);
         pxvz_ff <= MW'(req_data.quat_x) * MW'(req_data.vec_z);
         pxvy_ff <= MW'(req_data.quat_x) * MW'(req_data.vec_y);
         pyvx_ff <= MW'(req_data.quat_y) * MW'(req_data.vec_x);
      end
   end

   // stage 2: norm, scalar term, dot and cross products
   logic signed [SW-1:0]  nsum_in;
   logic [DW-1:0]         d2_ff;
   logic signed [SW-1:0]  s2_ff;
   logic signed [DTW-1:0] dot2_ff;
   logic signed [CW-1:0]  cx2_ff, cy2_ff, cz2_ff;
   logic signed [W2W-1:0] w2_ff;
   req_type               q2_ff;
   logic                  zero2_ff;

   assign nsum_in = SW'(pww_ff) + SW'(pxx_ff) + SW'(pyy_ff) + SW'(pzz_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d2_ff    <= nsum_in[DW-1:0];
         zero2_ff <= (nsum_in == '0);
         s2_ff    <= SW'(pww_ff) - SW'(pxx_ff) - SW'(pyy_ff) - SW'(pzz_ff);
         dot2_ff  <= (DTW'(pxvx_ff) + DTW'(pyvy_ff) + DTW'(pzvz_ff)) <<< 1;
         cx2_ff   <= CW'(pyvz_ff) - CW'(pzvy_ff);
         cy2_ff   <= CW'(pzvx_ff) - CW'(pxvz_ff);
         cz2_ff   <= CW'(pxvy_ff) - CW'(pyvx_ff);
         w2_ff    <= W2W'(s1_ff.quat_w) <<< 1;
         q2_ff    <= s1_ff;
      end
   end

   // stage 3: second-level products
   logic signed [SW+VEC_BITS-1:0]   tsx_ff, tsy_ff, tsz_ff;
   logic signed [DTW+QUAT_BITS-1:0] tdx_ff, tdy_ff, tdz_ff;
   logic signed [W2W+CW-1:0]        tcx_ff, tcy_ff, tcz_ff;
   logic [DW-1:0]                   d3_ff;
   logic                            zero3_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         tsx_ff   <= (SW+VEC_BITS)'(s2_ff) * (SW+VEC_BITS)'(q2_ff.vec_x);
         tsy_ff   <= (SW+VEC_BITS)'(s2_ff) * (SW+VEC_BITS)'(q2_ff.vec_y);
         tsz_ff   <= (SW+VEC_BITS)'(s2_ff) * (SW+VEC_BITS)'(q2_ff.vec_z);
         tdx_ff   <= (DTW+QUAT_BITS)'(dot2_ff) * (DTW+QUAT_BITS)'(q2_ff.quat_x);
         tdy_ff   <= (DTW+QUAT_BITS)'(dot2_ff) * (DTW+QUAT_BITS)'(q2_ff.quat_y);
         tdz_ff   <= (DTW+QUAT_BITS)'(dot2_ff) * (DTW+QUAT_BITS)'(q2_ff.quat_z);
         tcx_ff   <= (W2W+CW)'(w2_ff) * (W2W+CW)'(cx2_ff);
         tcy_ff   <= (W2W+CW)'(w2_ff) * (W2W+CW)'(cy2_ff);
         tcz_ff   <= (W2W+CW)'(w2_ff) * (W2W+CW)'(cz2_ff);
         d3_ff    <= d2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // stage 4: numerators, split into sign and magnitude
   logic signed [NW-1:0] nx_in, ny_in, nz_in;
   logic [NW-1:0]        dv_r_ff   [0:QNB][3];
   logic [QNB-1:0]       dv_q_ff   [0:QNB][3];
   logic [2:0]           dv_neg_ff [0:QNB];
   logic [DW-1:0]        dv_d_ff   [0:QNB];
   logic                 dv_zero_ff[0:QNB];

   assign nx_in = NW'(tsx_ff) + NW'(tdx_ff) + NW'(tcx_ff);
   assign ny_in = NW'(tsy_ff) + NW'(tdy_ff) + NW'(tcy_ff);
   assign nz_in = NW'(tsz_ff) + NW'(tdz_ff) + NW'(tcz_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         dv_r_ff[0][0]  <= nx_in[NW-1] ? NW'(-nx_in) : NW'(nx_in);
         dv_r_ff[0][1]  <= ny_in[NW-1] ? NW'(-ny_in) : NW'(ny_in);
         dv_r_ff[0][2]  <= nz_in[NW-1] ? NW'(-nz_in) : NW'(nz_in);
         dv_neg_ff[0]   <= {nz_in[NW-1], ny_in[NW-1], nx_in[NW-1]};
         dv_q_ff[0][0]  <= '0;
         dv_q_ff[0][1]  <= '0;
         dv_q_ff[0][2]  <= '0;
         // zero norm divides by one; result is forced to zero later
         dv_d_ff[0]     <= zero3_ff ? DW'(1) : d3_ff;
         dv_zero_ff[0]  <= zero3_ff;
      end
   end

   // restoring division, one quotient bit per stage, msb first
   genvar j, c;
   generate
      for (j = 1; j <= QNB; j++) begin : g_div
         localparam int SH = QNB - j;
         logic [CMPW-1:0] dsh;
         assign dsh = CMPW'(dv_d_ff[j-1]) << SH;
         for (c = 0; c < 3; c++) begin : g_comp
            logic ge;
            logic [CMPW-1:0] diff;
            assign ge   = CMPW'(dv_r_ff[j-1][c]) >= dsh;
            assign diff = CMPW'(dv_r_ff[j-1][c]) - dsh;
            always_ff @(posedge clock) begin
               if (en[4+j]) begin
                  dv_r_ff[j][c] <= ge ? diff[NW-1:0] : dv_r_ff[j-1][c];
                  dv_q_ff[j][c] <= {dv_q_ff[j-1][c][QNB-2:0], ge};
               end
            end
         end
         always_ff @(posedge clock) begin
            if (en[4+j]) begin
               dv_neg_ff[j]  <= dv_neg_ff[j-1];
               dv_d_ff[j]    <= dv_d_ff[j-1];
               dv_zero_ff[j] <= dv_zero_ff[j-1];
            end
         end
      end
   endgenerate

   // final stage: round half away from zero, saturate, apply sign
   localparam logic [QNB:0] LIM_NEG = (QNB+1)'(1) << (VEC_BITS - 1);
   logic [QNB:0]          quo   [3];
   logic [QNB:0]          lim   [3];
   logic [2:0]            clip;
   logic [VEC_BITS-1:0]   comp  [3];
   rsp_type               out_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo[i] = (QNB+1)'(dv_q_ff[QNB][i])
                  + (QNB+1)'({dv_r_ff[QNB][i], 1'b0} >= (NW+1)'(dv_d_ff[QNB]));
         lim[i] = dv_neg_ff[QNB][i] ? LIM_NEG : LIM_NEG - (QNB+1)'(1);
         clip[i] = quo[i] > lim[i];
         comp[i] = clip[i] ? lim[i][VEC_BITS-1:0] : quo[i][VEC_BITS-1:0];
         if (dv_neg_ff[QNB][i]) begin
            comp[i] = -comp[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NSTG]) begin
         if (dv_zero_ff[QNB]) begin
            out_ff.rot_x     <= '0;
            out_ff.rot_y     <= '0;
            out_ff.rot_z     <= '0;
            out_ff.zero_quat <= 1'b1;
            out_ff.clipped   <= 1'b0;
         end else begin
            out_ff.rot_x     <= comp[0];
            out_ff.rot_y     <= comp[1];
            out_ff.rot_z     <= comp[2];
            out_ff.zero_quat <= 1'b0;
            out_ff.clipped   <= |clip;
         end
      end
   end

   assign rsp_valid = vld_ff[NSTG];
   assign rsp_data  = out_ff;

endmodule

/* dv/quaternion_vector_rotate_tb.sv */
// testbench for quaternion_vector_rotate: directed table then random transfers
// depends on qvr_pkg and the quaternion_vector_rotate rtl
`timescale 1ns / 100ps

module quaternion_vector_rotate_tb
   import qvr_pkg::*;
();

   localparam int RANDOM_ITEMS = 1950;
   localparam int LATENCY      = NSTG;
   localparam int STALL_LIMIT  = 4000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   rsp_type expected_rotations[$];
   int      mismatch_count;
   int      checked_count;
   int      zero_count;
   int      clip_count;
   int      idle_cycles = 0;
   bit      sending_done;
   bit      quiet_mode;
   bit      hold_rsp;

   quaternion_vector_rotate DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock generation
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // round n / d to nearest, ties away from zero, saturate; returns clip flag
   function automatic bit round_and_saturate(input logic signed [127:0] num,
                                             input logic signed [127:0] den,
                                             output logic signed [VEC_BITS-1:0] res);
      logic [127:0]        mag;
      logic [127:0]        quo;
      logic [127:0]        rem;
      logic signed [127:0] lim;
      bit                  neg;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = mag / den;
      rem = mag % den;
      if (2 * rem >= den)
         quo = quo + 1;
      lim = neg ? (128'sd1 <<< (VEC_BITS - 1)) : ((128'sd1 <<< (VEC_BITS - 1)) - 1);
      if (quo > lim) begin
         res = neg ? -lim : lim;
         return 1'b1;
      end
      res = neg ? -$signed(quo) : $signed(quo);
      return 1'b0;
   endfunction

   // rotation predictor: v' = (s v + 2(u.v) u + 2w (u x v)) / |q|^2
   function automatic rsp_type predict_rotation(input req_type item);
      logic signed [127:0] w, x, y, z, vx, vy, vz;
      logic signed [127:0] norm, s, dot2, cx, cy, cz, nx, ny, nz;
      rsp_type             r;
      bit                  c0, c1, c2;
      w  = item.quat_w;  x  = item.quat_x;  y = item.quat_y;  z = item.quat_z;
      vx = item.vec_x;   vy = item.vec_y;   vz = item.vec_z;
      r = '0;
      norm = w*w + x*x + y*y + z*z;
      if (norm == 0) begin
         r.zero_quat = 1'b1;
         return r;
      end
      s    = w*w - (x*x + y*y + z*z);
      dot2 = 2 * (x*vx + y*vy + z*vz);
      cx = y*vz - z*vy;
      cy = z*vx - x*vz;
      cz = x*vy - y*vx;
      nx = s*vx + dot2*x + 2*w*cx;
      ny = s*vy + dot2*y + 2*w*cy;
      nz = s*vz + dot2*z + 2*w*cz;
      c0 = round_and_saturate(nx, norm, r.rot_x);
      c1 = round_and_saturate(ny, norm, r.rot_y);
      c2 = round_and_saturate(nz, norm, r.rot_z);
      r.clipped = c0 | c1 | c2;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("mismatch on %s at %0t: got %0d expected %0d", what, $time, got, want);
   endtask

   // send one transfer and queue its prediction (or the typed-in value)
   task automatic send_item(input req_type item, input bit use_given, input rsp_type given);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_rotations.push_back(use_given ? given : predict_rotation(item));
   endtask

   task automatic idle_sender();
      if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic req_type random_item();
      req_type      it;
      logic [127:0] raw;
      int           mode;
      raw  = {$urandom, $urandom, $urandom, $urandom};
      it   = raw[$bits(req_type)-1:0];
      mode = $urandom_range(0, 9);
      // small quaternions and vectors reach rounding ties and odd ratios
      if (mode < 2) begin
         it.quat_w = QUAT_BITS'($signed($urandom_range(0, 6)) - 3);
         it.quat_x = QUAT_BITS'($signed($urandom_range(0, 6)) - 3);
         it.quat_y = QUAT_BITS'($signed($urandom_range(0, 6)) - 3);
         it.quat_z = QUAT_BITS'($signed($urandom_range(0, 6)) - 3);
      end else if (mode == 2) begin
         it.quat_x = '0; it.quat_y = '0; it.quat_z = '0;
         if ($urandom_range(0, 1)) it.quat_w = '0;
      end
      if (mode == 3) begin
         it.vec_x = VEC_BITS'($signed($urandom_range(0, 200)) - 100);
         it.vec_y = VEC_BITS'($signed($urandom_range(0, 200)) - 100);
         it.vec_z = VEC_BITS'($signed($urandom_range(0, 200)) - 100);
      end
      return it;
   endfunction

   // directed table: quaternion, vector, whether expected is typed, expected
   typedef struct {
      req_type item;
      bit      given;
      rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic req_type mk(input int w, x, y, z, vx, vy, vz);
      req_type it;
      it.quat_w = QUAT_BITS'(w); it.quat_x = QUAT_BITS'(x);
      it.quat_y = QUAT_BITS'(y); it.quat_z = QUAT_BITS'(z);
      it.vec_x = VEC_BITS'(vx); it.vec_y = VEC_BITS'(vy); it.vec_z = VEC_BITS'(vz);
      return it;
   endfunction

   function automatic rsp_type mr(input int rx, ry, rz, input bit zq, input bit cl);
      rsp_type r;
      r.rot_x = VEC_BITS'(rx); r.rot_y = VEC_BITS'(ry); r.rot_z = VEC_BITS'(rz);
      r.zero_quat = zq; r.clipped = cl;
      return r;
   endfunction

   task automatic build_table();
      // zero quaternion
      directed_rows.push_back('{mk(0, 0, 0, 0, 100, -5, 7), 1, mr(0, 0, 0, 1, 0)});
      directed_rows.push_back('{mk(0, 0, 0, 0, -32768, 32767, -32768), 1, mr(0, 0, 0, 1, 0)});
      // identity rotations leave the vector alone
      directed_rows.push_back('{mk(16384, 0, 0, 0, 32767, -32768, 1), 1,
                                mr(32767, -32768, 1, 0, 0)});
      directed_rows.push_back('{mk(-32768, 0, 0, 0, -32768, -32768, -32768), 1,
                                mr(-32768, -32768, -32768, 0, 0)});
      directed_rows.push_back('{mk(1, 0, 0, 0, 5, 6, 7), 1, mr(5, 6, 7, 0, 0)});
      // half turns about x, y and z negate the other two components; -32768 saturates
      directed_rows.push_back('{mk(0, 16384, 0, 0, 3, -32768, 9), 1,
                                mr(3, 32767, -9, 0, 1)});
      directed_rows.push_back('{mk(0, 0, -32768, 0, 10, 20, 30), 1, mr(-10, 20, -30, 0, 0)});
      directed_rows.push_back('{mk(0, 0, 0, 32767, -32768, 1, 1), 1,
                                mr(32767, -1, 1, 0, 1)});
      // quarter turns, rounding and overflow via the predictor
      directed_rows.push_back('{mk(1, 1, 0, 0, 32767, 32767, 32767), 0, '0});
      directed_rows.push_back('{mk(1, 1, 1, 1, 32767, -32768, 32767), 0, '0});
      directed_rows.push_back('{mk(2, 1, 0, 0, 1, 1, 0), 0, '0});
      directed_rows.push_back('{mk(3, 1, 1, 0, 1, 2, 3), 0, '0});
      directed_rows.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, '0});
      directed_rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768),
                                0, '0});
      directed_rows.push_back('{mk(-1, -1, -1, -1, 0, 0, 0), 0, '0});
      directed_rows.push_back('{mk(11585, 11585, 0, 0, 32767, 32767, -32768), 0, '0});
      directed_rows.push_back('{mk(5, -3, 7, -2, -1, 1, -1), 0, '0});
   endtask

   // stimulus
   initial begin
      req_valid    = 1'b0;
      req_data     = '0;
      reset        = 1'b1;
      sending_done = 1'b0;
      quiet_mode   = 1'b0;
      build_table();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].given, directed_rows[i].want);
         idle_sender();
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // sender pauses until the pipeline has drained
         if (n == 600) begin
            req_valid <= 1'b0;
            while (expected_rotations.size() != 0) @(posedge clock);
         end
         if (n == RANDOM_ITEMS - 300) quiet_mode = 1'b1;
         send_item(random_item(), 1'b0, '0);
         idle_sender();
      end
      req_valid    <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver backpressure, with one long hold-off to fill the pipeline
   initial begin
      rsp_ready = 1'b0;
      hold_rsp  = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (checked_count >= 300 && !hold_rsp) begin
            hold_rsp = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LATENCY * 8) @(posedge clock);
         end
         if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rotations.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            rsp_type want;
            want = expected_rotations.pop_front();
            if (rsp_data.rot_x !== want.rot_x)
               report_mismatch("rot_x", rsp_data.rot_x, want.rot_x);
            if (rsp_data.rot_y !== want.rot_y)
               report_mismatch("rot_y", rsp_data.rot_y, want.rot_y);
            if (rsp_data.rot_z !== want.rot_z)
               report_mismatch("rot_z", rsp_data.rot_z, want.rot_z);
            if (rsp_data.zero_quat !== want.zero_quat)
               report_mismatch("zero_quat", rsp_data.zero_quat, want.zero_quat);
            if (rsp_data.clipped !== want.clipped)
               report_mismatch("clipped", rsp_data.clipped, want.clipped);
            zero_count += want.zero_quat;
            clip_count += want.clipped;
         end
         checked_count++;
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding",
                  expected_rotations.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // end of run
   initial begin
      mismatch_count = 0;
      checked_count  = 0;
      zero_count     = 0;
      clip_count     = 0;
      wait (sending_done);
      while (expected_rotations.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);
      $display("checked %0d rotations: %0d zero quaternions, %0d saturated",
               checked_count, zero_count, clip_count);
      if (mismatch_count == 0 && expected_rotations.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
